>>> rtl/lbmcol_pkg.sv
// shared types, constants and fixed-point helpers of the d2q9 collision unit
`timescale 1ns / 1ps
package lbmcol_pkg;

   localparam int NDIR = 9;
   localparam int DW   = 32;
   localparam int WW   = 72;

   typedef enum logic [2:0] {
      REG_RELAX_EVEN  = 3'd0,
      REG_RELAX_ODD   = 3'd1,
      REG_LAT_SPEED   = 3'd2,
      REG_REF_DENS    = 3'd3,
      REG_REF_RECIP   = 3'd4
   } csr_index_type;

   typedef logic signed [DW-1:0] pop_type;
   typedef logic signed [WW-1:0] wide_type;
   typedef logic signed [1:0]    dir_type;

   localparam dir_type DIR_X [NDIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                       2'sd1, -2'sd1, -2'sd1, 2'sd1};
   localparam dir_type DIR_Y [NDIR] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                       2'sd1, 2'sd1, -2'sd1, -2'sd1};
   localparam int OPP_DIR [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
   localparam logic [29:0] WEIGHT [NDIR] = '{30'd477218588,
      30'd119304647, 30'd119304647, 30'd119304647, 30'd119304647,
      30'd29826162, 30'd29826162, 30'd29826162, 30'd29826162};

   localparam wide_type SAT_MAX = 72'sd2147483647;
   localparam wide_type SAT_MIN = -72'sd2147483648;

   // round half up then arithmetic shift
   function automatic wide_type rnd_shr(input wide_type v, input int unsigned sh);
      wide_type half;
      half = 72'sd1 <<< (sh - 1);
      return (v + half) >>> sh;
   endfunction

   function automatic pop_type sat32(input wide_type v);
      pop_type r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/lbm_d2q9_node_collide_unit.sv
// d2q9 two-relaxation-time collision of one lattice node, fully pipelined
`timescale 1ns / 1ps
// Takes one node (nine Q2.30 populations) per clock and returns the nine
// post-collision populations, the density and the velocity. The depth is
// set by the chain of dependent multiplies (momentum, velocity and squares,
// reference density, weight, relaxation rates), each followed by a register.
// A full output register with rsp_tready low stalls the whole pipeline;
// nothing is dropped or repeated. The user must write registers through the
// csr port only while no node is in flight; the block does not enforce it.
module lbm_d2q9_node_collide_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,   // pop_0 .. pop_8, 32 bits each
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [383:0] rsp_tdata,   // post_0 .. post_8, density, vel_x, vel_y
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import lbmcol_pkg::*;

   localparam int NST = 11;

   logic signed [31:0] relax_even_ff, relax_odd_ff;
   logic [31:0]        lat_speed_ff;
   logic [30:0]        ref_dens_ff, ref_recip_ff;

   logic [NST:1] vld_ff;
   logic         adv;

   pop_type f_ff   [1:10][NDIR];
   pop_type rho_ff [1:11];
   pop_type vx_ff  [5:11];
   pop_type vy_ff  [5:11];

   pop_type            jx1_ff, jy1_ff;
   logic signed [63:0] pjx2_ff, pjy2_ff;
   pop_type            mx3_ff, my3_ff;
   logic signed [64:0] pvx4_ff, pvy4_ff;
   logic signed [63:0] pmx4_ff, pmy4_ff;
   logic signed [63:0] pem4_ff [NDIR];
   pop_type            em4_ff  [NDIR];
   pop_type            p5_ff   [NDIR];
   logic signed [63:0] pr6_ff  [NDIR];
   pop_type            s7_ff   [NDIR];
   logic signed [63:0] pw8_ff  [NDIR];
   logic signed [34:0] ev9_ff  [NDIR];
   logic signed [34:0] od9_ff  [NDIR];
   logic signed [66:0] pe10_ff [NDIR];
   logic signed [66:0] po10_ff [NDIR];
   pop_type            post11_ff [NDIR];

   pop_type            f_in   [NDIR];
   pop_type            rho1_in, jx1_in, jy1_in;
   pop_type            em4_in [NDIR];
   pop_type            p5_in  [NDIR];
   pop_type            s7_in  [NDIR];
   logic signed [34:0] ev9_in [NDIR];
   logic signed [34:0] od9_in [NDIR];
   pop_type            post11_in [NDIR];

   assign adv        = !vld_ff[NST] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NST];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_even_ff <= -32'sd1073741824;
         relax_odd_ff  <= -32'sd1073741824;
         lat_speed_ff  <= 32'd16777216;
         ref_dens_ff   <= 31'd1073741824;
         ref_recip_ff  <= 31'd1073741824;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RELAX_EVEN: relax_even_ff <= csr_data;
            REG_RELAX_ODD:  relax_odd_ff  <= csr_data;
            REG_LAT_SPEED:  lat_speed_ff  <= csr_data;
            REG_REF_DENS:   ref_dens_ff   <= csr_data[30:0];
            REG_REF_RECIP:  ref_recip_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-1:1], req_tvalid};
      end
   end

   // stage 1: density and momentum sums
   always_comb begin
      logic signed [35:0] rs, xs, ys;
      for (int k = 0; k < NDIR; k++) begin
         f_in[k] = req_tdata[k*DW +: DW];
      end
      rs = '0;
      xs = '0;
      ys = '0;
      for (int k = 0; k < NDIR; k++) begin
         rs = rs + 36'(f_in[k]);
         if (DIR_X[k] > 0) xs = xs + 36'(f_in[k]);
         if (DIR_X[k] < 0) xs = xs - 36'(f_in[k]);
         if (DIR_Y[k] > 0) ys = ys + 36'(f_in[k]);
         if (DIR_Y[k] < 0) ys = ys - 36'(f_in[k]);
      end
      rho1_in = sat32(72'(rs));
      jx1_in  = sat32(72'(xs));
      jy1_in  = sat32(72'(ys));
   end

   // stage 4: projections of momentum on each direction
   always_comb begin
      wide_type a;
      for (int k = 0; k < NDIR; k++) begin
         a = '0;
         if (DIR_X[k] > 0) a = a + 72'(mx3_ff);
         if (DIR_X[k] < 0) a = a - 72'(mx3_ff);
         if (DIR_Y[k] > 0) a = a + 72'(my3_ff);
         if (DIR_Y[k] < 0) a = a - 72'(my3_ff);
         em4_in[k] = sat32(a);
      end
   end

   // stage 5: equilibrium polynomial
   always_comb begin
      wide_type mm, em2, t;
      mm = rnd_shr(72'(pmx4_ff), 30) + rnd_shr(72'(pmy4_ff), 30);
      for (int k = 0; k < NDIR; k++) begin
         em2 = rnd_shr(72'(pem4_ff[k]), 30);
         t = 72'sd6 * 72'(em4_ff[k]) + 72'sd9 * em2 - 72'sd3 * mm;
         p5_in[k] = sat32(rnd_shr(t, 1));
      end
   end

   // stage 7: density plus scaled polynomial
   always_comb begin
      for (int k = 0; k < NDIR; k++) begin
         s7_in[k] = sat32(72'(rho_ff[6]) + rnd_shr(72'(pr6_ff[k]), 30));
      end
   end

   // stage 9: non-equilibrium even and odd parts
   always_comb begin
      logic signed [34:0] nq [NDIR];
      wide_type feq;
      for (int k = 0; k < NDIR; k++) begin
         feq   = rnd_shr(72'(pw8_ff[k]), 30);
         nq[k] = 35'(f_ff[8][k]) - 35'(feq);
      end
      for (int k = 0; k < NDIR; k++) begin
         ev9_in[k] = 35'(rnd_shr(72'(nq[k]) + 72'(nq[OPP_DIR[k]]), 1));
         od9_in[k] = 35'(rnd_shr(72'(nq[k]) - 72'(nq[OPP_DIR[k]]), 1));
      end
   end

   // stage 11: relaxed populations
   always_comb begin
      for (int k = 0; k < NDIR; k++) begin
         post11_in[k] = sat32(72'(f_ff[10][k]) + rnd_shr(72'(pe10_ff[k]), 30)
                              + rnd_shr(72'(po10_ff[k]), 30));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff[1]   <= f_in;
         rho_ff[1] <= rho1_in;
         jx1_ff    <= jx1_in;
         jy1_ff    <= jy1_in;
         for (int s = 2; s <= 10; s++) f_ff[s] <= f_ff[s-1];
         for (int s = 2; s <= 11; s++) rho_ff[s] <= rho_ff[s-1];
         for (int s = 6; s <= 11; s++) begin
            vx_ff[s] <= vx_ff[s-1];
            vy_ff[s] <= vy_ff[s-1];
         end
         pjx2_ff <= jx1_ff * $signed({1'b0, ref_recip_ff});
         pjy2_ff <= jy1_ff * $signed({1'b0, ref_recip_ff});
         mx3_ff  <= sat32(rnd_shr(72'(pjx2_ff), 30));
         my3_ff  <= sat32(rnd_shr(72'(pjy2_ff), 30));
         pvx4_ff <= mx3_ff * $signed({1'b0, lat_speed_ff});
         pvy4_ff <= my3_ff * $signed({1'b0, lat_speed_ff});
         pmx4_ff <= mx3_ff * mx3_ff;
         pmy4_ff <= my3_ff * my3_ff;
         vx_ff[5] <= sat32(rnd_shr(72'(pvx4_ff), 24));
         vy_ff[5] <= sat32(rnd_shr(72'(pvy4_ff), 24));
         for (int k = 0; k < NDIR; k++) begin
            em4_ff[k]    <= em4_in[k];
            pem4_ff[k]   <= em4_in[k] * em4_in[k];
            p5_ff[k]     <= p5_in[k];
            pr6_ff[k]    <= p5_ff[k] * $signed({1'b0, ref_dens_ff});
            s7_ff[k]     <= s7_in[k];
            pw8_ff[k]    <= s7_ff[k] * $signed({1'b0, WEIGHT[k]});
            ev9_ff[k]    <= ev9_in[k];
            od9_ff[k]    <= od9_in[k];
            pe10_ff[k]   <= relax_even_ff * ev9_ff[k];
            po10_ff[k]   <= relax_odd_ff * od9_ff[k];
            post11_ff[k] <= post11_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NDIR; k++) begin
         rsp_tdata[k*DW +: DW] = post11_ff[k];
      end
      rsp_tdata[NDIR*DW +: DW]     = rho_ff[11];
      rsp_tdata[(NDIR+1)*DW +: DW] = vx_ff[11];
      rsp_tdata[(NDIR+2)*DW +: DW] = vy_ff[11];
   end

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[1])
      else $error("accepted node did not enter the pipeline");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("stall without a blocked result");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
